### hw/rtl/sla_pkg.sv
package sla_pkg;

    // Field widths of one request word and one result word.
    localparam int OP_W       = 3;
    localparam int IDX_W      = 10;
    localparam int LEN_W      = 5;
    localparam int MARK_W     = 11;
    localparam int STATUS_W   = 2;
    localparam int CAP_W      = 11;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 24;
    localparam int M_PAD_W    = M_TDATA_W - IDX_W - STATUS_W - MARK_W;

    localparam int CAP_RESET  = 1024;

    // Request codes.
    localparam logic [OP_W-1:0] OP_ALLOC_ONE = 3'd0;
    localparam logic [OP_W-1:0] OP_ALLOC_RUN = 3'd1;
    localparam logic [OP_W-1:0] OP_FREE_ONE  = 3'd2;
    localparam logic [OP_W-1:0] OP_FREE_RUN  = 3'd3;
    localparam logic [OP_W-1:0] OP_RESET     = 3'd4;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EXHAUSTED = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_BAD_ARG   = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd3;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } fsm_state_t;

    typedef struct packed {
        logic capture;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic out_busy;
    } dp_status_t;

endpackage

### hw/rtl/slot_allocator_with_free_lists.sv
// Slot allocator with a high-water mark and LIFO free lists per size class.
// Request words arrive on the s_ stream: op, slot_index and range_length.
// Every request word produces exactly one result word on the m_ stream:
// granted_index, status and the high-water mark after the request.
// The cfg_ channel writes the capacity register (slots usable by bumping);
// cfg_ready is always high, and writes are expected only while idle.
// For each request, the accept cycle reads the top of the single stack and of
// the addressed run stack, and the execute cycle decides, pushes into a stack
// memory and loads the output register. A new request is taken in the cycle
// after the previous result is loaded, and never while one is executing.
// The result word sits in an output register, so the next request is accepted
// while a result waits; if the receiver stalls, that request holds in the
// execute cycle until the output register drains.
// Reset clears the mark, all free-list counts and the output valid, and sets
// capacity to 1024. The stack memories are not cleared; the counts guard them.
module slot_allocator_with_free_lists #(
    parameter int HEAP_SLOTS = 1024,
    parameter int MAX_RUN    = 16,
    parameter int RUN_SLOTS  = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // s_tdata: op[2:0], slot_index[12:3], range_length[17:13], zero pad
    input  logic [sla_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // m_tdata: granted_index[9:0], status[11:10], high_water[22:12], zero pad
    output logic [sla_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [sla_pkg::CAP_W-1:0]      cfg_data
);
    import sla_pkg::*;

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    assign cfg_ready = 1'b1;

    sla_controller u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .dp_status (dp_status),
        .dp_cmd    (dp_cmd)
    );

    sla_datapath #(
        .HEAP_SLOTS (HEAP_SLOTS),
        .MAX_RUN    (MAX_RUN),
        .RUN_SLOTS  (RUN_SLOTS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .dp_cmd    (dp_cmd),
        .dp_status (dp_status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

### hw/rtl/sla_controller.sv
module sla_controller (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  sla_pkg::dp_status_t  dp_status,
    output sla_pkg::dp_cmd_t     dp_cmd
);
    import sla_pkg::*;

    fsm_state_t state_reg;
    fsm_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!dp_status.out_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready       = 1'b0;
        dp_cmd.capture = 1'b0;
        dp_cmd.commit  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready       = 1'b1;
                dp_cmd.capture = s_tvalid;
            end
            ST_EXEC: begin
                // The result word can only be loaded once the output register frees up.
                dp_cmd.commit = !dp_status.out_busy;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

### hw/rtl/sla_datapath.sv
module sla_datapath #(
    parameter int HEAP_SLOTS = 1024,
    parameter int MAX_RUN    = 16,
    parameter int RUN_SLOTS  = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [sla_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                           cfg_valid,
    input  logic [sla_pkg::CAP_W-1:0]      cfg_data,
    input  sla_pkg::dp_cmd_t               dp_cmd,
    output sla_pkg::dp_status_t            dp_status,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [sla_pkg::M_TDATA_W-1:0]  m_tdata
);
    import sla_pkg::*;

    localparam int SCW    = $clog2(HEAP_SLOTS + 1);
    localparam int SAW    = $clog2(HEAP_SLOTS);
    localparam int RCW    = $clog2(RUN_SLOTS + 1);
    localparam int RDEPTH = MAX_RUN * RUN_SLOTS;
    localparam int RAW    = (RDEPTH > 1) ? $clog2(RDEPTH) : 1;
    localparam int CLW    = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;

    localparam logic [RAW-1:0] RUN_SLOTS_A = RAW'(RUN_SLOTS);
    localparam logic [SCW-1:0] SINGLE_FULL = SCW'(HEAP_SLOTS);
    localparam logic [RCW-1:0] RUN_FULL    = RCW'(RUN_SLOTS);

    // Stack memories; entries are only used below the matching fill count.
    logic [IDX_W-1:0] single_mem [HEAP_SLOTS];
    logic [IDX_W-1:0] run_mem    [RDEPTH];

    logic [CAP_W-1:0]  capacity_reg;
    logic [MARK_W-1:0] mark_reg;
    logic [MARK_W-1:0] mark_next;
    logic [SCW-1:0]    single_cnt_reg;
    logic [SCW-1:0]    single_cnt_next;
    logic [RCW-1:0]    run_cnt_reg [MAX_RUN];

    logic [OP_W-1:0]   op_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [LEN_W-1:0]  len_reg;
    logic              len_ok_reg;
    logic [CLW-1:0]    cls_reg;
    logic [RAW-1:0]    run_base_reg;
    logic [IDX_W-1:0]  single_rd_reg;
    logic [IDX_W-1:0]  run_rd_reg;

    logic                out_valid_reg;
    logic [IDX_W-1:0]    granted_reg;
    logic [STATUS_W-1:0] status_reg;

    // Request fields, unpacked for the capture cycle.
    logic [OP_W-1:0]  op_in;
    logic [IDX_W-1:0] idx_in;
    logic [LEN_W-1:0] len_in;
    logic [LEN_W-1:0] len_m1_in;
    logic             len_ok_in;
    logic [CLW-1:0]   cls_in;
    logic [RAW-1:0]   run_base_in;
    logic [RCW-1:0]   run_cnt_in;

    assign op_in       = s_tdata[OP_W-1:0];
    assign idx_in      = s_tdata[OP_W +: IDX_W];
    assign len_in      = s_tdata[OP_W + IDX_W +: LEN_W];
    assign len_m1_in   = len_in - 1'b1;
    assign len_ok_in   = (len_in != '0) && (int'(len_in) <= MAX_RUN);
    assign cls_in      = len_ok_in ? CLW'(len_m1_in) : '0;
    assign run_base_in = RAW'(cls_in) * RUN_SLOTS_A;
    assign run_cnt_in  = run_cnt_reg[cls_in];

    // Execute-cycle decision.
    logic [MARK_W-1:0]   cap;
    logic [MARK_W:0]     mark_plus_len;
    logic [MARK_W-1:0]   idx_end;
    logic [RCW-1:0]      run_cnt;
    logic [RCW-1:0]      run_cnt_new;
    logic                run_cnt_we;
    logic                single_we;
    logic                run_we;
    logic                clear_all;
    logic [IDX_W-1:0]    granted;
    logic [STATUS_W-1:0] status;

    assign cap           = (int'(capacity_reg) < HEAP_SLOTS) ? capacity_reg
                                                             : MARK_W'(HEAP_SLOTS);
    assign mark_plus_len = {1'b0, mark_reg} + (MARK_W + 1)'(len_reg);
    assign idx_end       = MARK_W'(idx_reg) + MARK_W'(len_reg);
    assign run_cnt       = run_cnt_reg[cls_reg];

    always_comb begin
        granted         = '0;
        status          = STAT_OK;
        mark_next       = mark_reg;
        single_cnt_next = single_cnt_reg;
        run_cnt_new     = run_cnt;
        run_cnt_we      = 1'b0;
        single_we       = 1'b0;
        run_we          = 1'b0;
        clear_all       = 1'b0;
        case (op_reg)
            OP_ALLOC_ONE: begin
                if (single_cnt_reg != '0) begin
                    single_cnt_next = single_cnt_reg - 1'b1;
                    granted         = single_rd_reg;
                end else if (mark_reg < cap) begin
                    granted   = IDX_W'(mark_reg);
                    mark_next = mark_reg + 1'b1;
                end else begin
                    status = STAT_EXHAUSTED;
                end
            end
            OP_ALLOC_RUN: begin
                if (!len_ok_reg) begin
                    status = STAT_BAD_ARG;
                end else if (run_cnt != '0) begin
                    run_cnt_we  = 1'b1;
                    run_cnt_new = run_cnt - 1'b1;
                    granted     = run_rd_reg;
                end else if (mark_plus_len <= {1'b0, cap}) begin
                    granted   = IDX_W'(mark_reg);
                    mark_next = MARK_W'(mark_plus_len);
                end else begin
                    status = STAT_EXHAUSTED;
                end
            end
            OP_FREE_ONE: begin
                if (MARK_W'(idx_reg) >= mark_reg) begin
                    status = STAT_BAD_ARG;
                end else if (single_cnt_reg == SINGLE_FULL) begin
                    status = STAT_FULL;
                end else begin
                    single_we       = 1'b1;
                    single_cnt_next = single_cnt_reg + 1'b1;
                end
            end
            OP_FREE_RUN: begin
                if (!len_ok_reg || (idx_end > mark_reg)) begin
                    status = STAT_BAD_ARG;
                end else if (run_cnt == RUN_FULL) begin
                    status = STAT_FULL;
                end else begin
                    run_we      = 1'b1;
                    run_cnt_we  = 1'b1;
                    run_cnt_new = run_cnt + 1'b1;
                end
            end
            OP_RESET: begin
                clear_all       = 1'b1;
                mark_next       = '0;
                single_cnt_next = '0;
            end
            default: begin
                status = STAT_BAD_ARG;
            end
        endcase
    end

    // Capacity register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAP_W'(CAP_RESET);
        end else if (cfg_valid) begin
            capacity_reg <= cfg_data;
        end
    end

    // Allocator control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mark_reg       <= '0;
            single_cnt_reg <= '0;
            for (int i = 0; i < MAX_RUN; i++) begin
                run_cnt_reg[i] <= '0;
            end
        end else if (dp_cmd.commit) begin
            mark_reg       <= mark_next;
            single_cnt_reg <= single_cnt_next;
            if (clear_all) begin
                for (int i = 0; i < MAX_RUN; i++) begin
                    run_cnt_reg[i] <= '0;
                end
            end else if (run_cnt_we) begin
                run_cnt_reg[cls_reg] <= run_cnt_new;
            end
        end
    end

    // Request capture; the stack tops are read in the same cycle.
    always_ff @(posedge aclk) begin
        if (dp_cmd.capture) begin
            op_reg       <= op_in;
            idx_reg      <= idx_in;
            len_reg      <= len_in;
            len_ok_reg   <= len_ok_in;
            cls_reg      <= cls_in;
            run_base_reg <= run_base_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (dp_cmd.capture) begin
            single_rd_reg <= single_mem[SAW'(single_cnt_reg - 1'b1)];
            run_rd_reg    <= run_mem[run_base_in + RAW'(run_cnt_in - 1'b1)];
        end
        if (dp_cmd.commit && single_we) begin
            single_mem[SAW'(single_cnt_reg)] <= idx_reg;
        end
        if (dp_cmd.commit && run_we) begin
            run_mem[run_base_reg + RAW'(run_cnt)] <= idx_reg;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (dp_cmd.commit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (dp_cmd.commit) begin
            granted_reg <= granted;
            status_reg  <= status;
        end
    end

    assign dp_status.out_busy = out_valid_reg && !m_tready;
    assign m_tvalid           = out_valid_reg;
    // The mark only moves when a result word is loaded, so it is the word's high-water field.
    assign m_tdata            = {M_PAD_W'(0), mark_reg, status_reg, granted_reg};

    a_commit_shows_word: assert property (@(posedge aclk) disable iff (!aresetn)
        dp_cmd.commit |=> m_tvalid)
        else $error("result word not presented after commit");

    a_granted_zero_on_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (status_reg != STAT_OK)) |-> (granted_reg == '0))
        else $error("nonzero index on a failed request");

    a_single_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        single_cnt_reg <= SINGLE_FULL)
        else $error("single free count beyond stack depth");

    a_reset_op_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (dp_cmd.commit && (op_reg == OP_RESET))
            |=> ((mark_reg == '0) && (single_cnt_reg == '0)))
        else $error("reset request left allocator state behind");

    a_no_capture_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        dp_cmd.capture |=> !dp_cmd.capture)
        else $error("second request captured before the first executed");

endmodule

### verif/slot_allocator_with_free_lists_tb.sv
`timescale 1ns / 100ps

module slot_allocator_with_free_lists_tb;
    import sla_pkg::*;

    localparam int HEAP       = 1024;
    localparam int RUN_MAX    = 16;
    localparam int RUN_DEPTH  = 32;

    localparam int NUM_PHASES      = 10;
    localparam int ITEMS_PER_PHASE = 12;
    localparam int FILL_PHASE      = 4;
    localparam int HOLD_PHASE      = 3;
    localparam int LONG_HOLD       = 300;
    localparam int DRAIN_CYCLES    = 8;
    localparam int WATCHDOG_LIMIT  = 2000;

    // Op codes the block does not define; they must come back as a bad argument.
    localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [IDX_W-1:0] idx;
        logic [OP_W-1:0]  op;
    } request_t;

    typedef struct packed {
        logic [MARK_W-1:0]   high_water;
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    granted;
    } result_t;

    localparam int REQ_W = $bits(request_t);
    localparam int RES_W = $bits(result_t);

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [IDX_W-1:0]    idx;
        logic [LEN_W-1:0]    len;
        logic                typed;
        logic [IDX_W-1:0]    granted;
        logic [STATUS_W-1:0] status;
        logic [MARK_W-1:0]   high_water;
    } dir_row_t;

    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_COIN,
        RDY_EVERY_THIRD,
        RDY_SPARSE
    } ready_mode_t;

    // Rows with typed set carry a result read straight off the spec; the rest
    // are checked against the allocator mirror.
    localparam dir_row_t DIR_ROWS [26] = '{
        '{OP_FREE_ONE,  10'd0,    5'd0,  1'b1, 10'd0,  STAT_BAD_ARG, 11'd0},
        '{OP_ALLOC_ONE, 10'd0,    5'd0,  1'b1, 10'd0,  STAT_OK,      11'd1},
        '{OP_ALLOC_RUN, 10'd0,    5'd0,  1'b1, 10'd0,  STAT_BAD_ARG, 11'd1},
        '{OP_ALLOC_RUN, 10'd0,    5'd17, 1'b1, 10'd0,  STAT_BAD_ARG, 11'd1},
        '{OP_ALLOC_RUN, 10'd1023, 5'd31, 1'b1, 10'd0,  STAT_BAD_ARG, 11'd1},
        '{OP_ALLOC_RUN, 10'd0,    5'd16, 1'b1, 10'd1,  STAT_OK,      11'd17},
        '{OP_ALLOC_RUN, 10'd0,    5'd1,  1'b1, 10'd17, STAT_OK,      11'd18},
        '{OP_FREE_ONE,  10'd18,   5'd0,  1'b1, 10'd0,  STAT_BAD_ARG, 11'd18},
        '{OP_FREE_ONE,  10'd1023, 5'd31, 1'b1, 10'd0,  STAT_BAD_ARG, 11'd18},
        '{OP_FREE_ONE,  10'd0,    5'd0,  1'b1, 10'd0,  STAT_OK,      11'd18},
        '{OP_FREE_ONE,  10'd0,    5'd0,  1'b0, 10'd0,  STAT_OK,      11'd0},
        '{OP_ALLOC_ONE, 10'd0,    5'd0,  1'b0, 10'd0,  STAT_OK,      11'd0},
        '{OP_ALLOC_ONE, 10'd0,    5'd0,  1'b0, 10'd0,  STAT_OK,      11'd0},
        '{OP_FREE_RUN,  10'd1,    5'd16, 1'b0, 10'd0,  STAT_OK,      11'd0},
        '{OP_FREE_RUN,  10'd3,    5'd16, 1'b1, 10'd0,  STAT_BAD_ARG, 11'd18},
        '{OP_FREE_RUN,  10'd0,    5'd0,  1'b1, 10'd0,  STAT_BAD_ARG, 11'd18},
        '{OP_FREE_RUN,  10'd0,    5'd17, 1'b1, 10'd0,  STAT_BAD_ARG, 11'd18},
        '{OP_ALLOC_RUN, 10'd0,    5'd16, 1'b0, 10'd0,  STAT_OK,      11'd0},
        '{OP_UNUSED_LO, 10'd0,    5'd0,  1'b1, 10'd0,  STAT_BAD_ARG, 11'd18},
        '{OP_UNUSED_HI, 10'd1023, 5'd31, 1'b1, 10'd0,  STAT_BAD_ARG, 11'd18},
        '{OP_ALLOC_ONE, 10'd0,    5'd0,  1'b0, 10'd0,  STAT_OK,      11'd0},
        '{OP_RESET,     10'd0,    5'd0,  1'b1, 10'd0,  STAT_OK,      11'd0},
        '{OP_ALLOC_RUN, 10'd1023, 5'd16, 1'b1, 10'd0,  STAT_OK,      11'd16},
        '{OP_FREE_RUN,  10'd0,    5'd16, 1'b0, 10'd0,  STAT_OK,      11'd0},
        '{OP_RESET,     10'd0,    5'd0,  1'b1, 10'd0,  STAT_OK,      11'd0},
        '{OP_ALLOC_RUN, 10'd0,    5'd16, 1'b1, 10'd0,  STAT_OK,      11'd16}
    };

    localparam logic [CAP_W-1:0] PHASE_CAPS [NUM_PHASES] = '{
        11'd2047, 11'd0, 11'd1, 11'd24, 11'd1024,
        11'd200, 11'd3, 11'd1023, 11'd600, 11'd1025
    };

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CAP_W-1:0]     cfg_data  = '0;

    // Mirror of the allocator state.
    logic [CAP_W-1:0] cap_reg;
    int unsigned      hw_mark;
    logic [IDX_W-1:0] one_stack [HEAP];
    int unsigned      one_depth;
    logic [IDX_W-1:0] run_stack [RUN_MAX][RUN_DEPTH];
    int unsigned      run_depth [RUN_MAX];

    result_t expected_results [$];
    int      fail_count   = 0;
    int      idle_cycles  = 0;
    int      burst_left   = 0;
    bit      long_hold_req = 1'b0;

    slot_allocator_with_free_lists #(
        .HEAP_SLOTS (HEAP),
        .MAX_RUN    (RUN_MAX),
        .RUN_SLOTS  (RUN_DEPTH)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic result_t apply_request(input request_t rq);
        result_t     r;
        int unsigned usable;
        int unsigned l;
        r = '0;
        r.status = STAT_OK;
        usable = (cap_reg < HEAP) ? cap_reg : HEAP;
        l = rq.len;
        case (rq.op)
            OP_ALLOC_ONE: begin
                if (one_depth > 0) begin
                    one_depth--;
                    r.granted = one_stack[one_depth];
                end else if (hw_mark < usable) begin
                    r.granted = IDX_W'(hw_mark);
                    hw_mark++;
                end else begin
                    r.status = STAT_EXHAUSTED;
                end
            end
            OP_ALLOC_RUN: begin
                if (l == 0 || l > RUN_MAX) begin
                    r.status = STAT_BAD_ARG;
                end else if (run_depth[l-1] > 0) begin
                    run_depth[l-1]--;
                    r.granted = run_stack[l-1][run_depth[l-1]];
                end else if (hw_mark + l <= usable) begin
                    r.granted = IDX_W'(hw_mark);
                    hw_mark += l;
                end else begin
                    r.status = STAT_EXHAUSTED;
                end
            end
            OP_FREE_ONE: begin
                if (rq.idx >= hw_mark) begin
                    r.status = STAT_BAD_ARG;
                end else if (one_depth >= HEAP) begin
                    r.status = STAT_FULL;
                end else begin
                    one_stack[one_depth] = rq.idx;
                    one_depth++;
                end
            end
            OP_FREE_RUN: begin
                if (l == 0 || l > RUN_MAX || rq.idx + l > hw_mark) begin
                    r.status = STAT_BAD_ARG;
                end else if (run_depth[l-1] >= RUN_DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    run_stack[l-1][run_depth[l-1]] = rq.idx;
                    run_depth[l-1]++;
                end
            end
            OP_RESET: begin
                hw_mark = 0;
                one_depth = 0;
                for (int k = 0; k < RUN_MAX; k++) run_depth[k] = 0;
            end
            default: r.status = STAT_BAD_ARG;
        endcase
        if (r.status != STAT_OK) r.granted = '0;
        r.high_water = MARK_W'(hw_mark);
        return r;
    endfunction

    function automatic request_t make_request(input logic [OP_W-1:0] op,
                                              input int unsigned idx,
                                              input int unsigned len);
        request_t rq;
        rq.op  = op;
        rq.idx = IDX_W'(idx);
        rq.len = LEN_W'(len);
        return rq;
    endfunction

    // Mostly allocations and well-formed frees that land below the mark, so the stacks
    // fill and get popped; the rest is resets, bad lengths, unknown ops and raw noise.
    function automatic request_t pick_request();
        request_t    rq;
        int unsigned dice;
        rq = make_request(OP_ALLOC_ONE, $urandom_range(0, HEAP - 1),
                          $urandom_range(1, RUN_MAX));
        dice = $urandom_range(0, 99);
        if (dice < 28) begin
            rq.op = OP_ALLOC_ONE;
        end else if (dice < 52) begin
            rq.op = OP_ALLOC_RUN;
            if ($urandom_range(0, 9) == 0) rq.len = LEN_W'($urandom_range(0, 31));
        end else if (dice < 68) begin
            rq.op = OP_FREE_ONE;
            if (hw_mark > 0 && $urandom_range(0, 4) != 0)
                rq.idx = IDX_W'($urandom_range(0, hw_mark - 1));
        end else if (dice < 88) begin
            rq.op = OP_FREE_RUN;
            if ($urandom_range(0, 9) == 0)
                rq.len = LEN_W'($urandom_range(0, 31));
            else if (hw_mark >= rq.len && $urandom_range(0, 4) != 0)
                rq.idx = IDX_W'($urandom_range(0, hw_mark - rq.len));
        end else if (dice < 91) begin
            rq.op = OP_RESET;
        end else if (dice < 94) begin
            rq.op = OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        end else begin
            rq = REQ_W'($urandom());
        end
        return rq;
    endfunction

    task automatic send_request(input request_t rq, input logic typed,
                                input result_t typed_res);
        result_t mirror_res;
        result_t queued_res;
        int      gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(0, 40);
        end else begin
            burst_left--;
        end
        s_tdata  <= {{(S_TDATA_W - REQ_W){1'b0}}, rq};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        mirror_res = apply_request(rq);
        queued_res = typed ? typed_res : mirror_res;
        expected_results = {expected_results, queued_res};
    endtask

    task automatic pause_until_drained();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        cap_reg = value;
    endtask

    task automatic check_field(input string name, input logic [MARK_W-1:0] want,
                               input logic [MARK_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    // The receiver switches between ready patterns of random length, and once
    // holds off for a long stretch so the result register backs up.
    always @(posedge aclk) begin : result_sink
        int unsigned hold_left;
        int unsigned pattern_left;
        int unsigned cyc;
        ready_mode_t ready_mode;
        if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left = LONG_HOLD;
        end
        cyc++;
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            if (pattern_left == 0) begin
                ready_mode = ready_mode_t'($urandom_range(0, 3));
                pattern_left = $urandom_range(16, 96);
            end else begin
                pattern_left--;
            end
            case (ready_mode)
                RDY_ALWAYS:      m_tready <= 1'b1;
                RDY_COIN:        m_tready <= 1'($urandom_range(0, 1));
                RDY_EVERY_THIRD: m_tready <= (cyc % 3 == 0);
                default:         m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge aclk) begin : result_check
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = result_t'(m_tdata[RES_W-1:0]);
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result word, granted_index %0d status %0d high_water %0d",
                         $time, got.granted, got.status, got.high_water);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("granted_index", MARK_W'(want.granted), MARK_W'(got.granted));
                check_field("status", MARK_W'(want.status), MARK_W'(got.status));
                check_field("high_water", want.high_water, got.high_water);
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no word moved for %0d cycles, %0d results outstanding",
                     $time, WATCHDOG_LIMIT, expected_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        dir_row_t row;
        cap_reg   = CAP_W'(CAP_RESET);
        hw_mark   = 0;
        one_depth = 0;
        for (int k = 0; k < RUN_MAX; k++) run_depth[k] = 0;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (DIR_ROWS[i]) begin
            row = DIR_ROWS[i];
            send_request(make_request(row.op, row.idx, row.len), row.typed,
                         '{high_water: row.high_water, status: row.status,
                           granted: row.granted});
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            pause_until_drained();
            write_capacity(PHASE_CAPS[ph]);
            if (ph == HOLD_PHASE) long_hold_req = 1'b1;
            if (ph == FILL_PHASE) begin
                // Push both kinds of stack past their depth so the last free
                // of each is dropped, then pop once from each.
                send_request(make_request(OP_RESET, 0, 0), 1'b0, '0);
                send_request(make_request(OP_ALLOC_RUN, 0, RUN_MAX), 1'b0, '0);
                repeat (HEAP + 1)
                    send_request(make_request(OP_FREE_ONE, $urandom_range(0, RUN_MAX - 1),
                                              $urandom_range(0, 31)), 1'b0, '0);
                send_request(make_request(OP_ALLOC_ONE, 0, 0), 1'b0, '0);
                repeat (RUN_DEPTH + 1)
                    send_request(make_request(OP_FREE_RUN, $urandom_range(0, RUN_MAX - 1),
                                              1), 1'b0, '0);
                send_request(make_request(OP_ALLOC_RUN, 0, 1), 1'b0, '0);
            end
            repeat (ITEMS_PER_PHASE) send_request(pick_request(), 1'b0, '0);
        end

        pause_until_drained();
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### files.f
hw/rtl/sla_pkg.sv
hw/rtl/sla_controller.sv
hw/rtl/sla_datapath.sv
hw/rtl/slot_allocator_with_free_lists.sv
verif/slot_allocator_with_free_lists_tb.sv
